// File: design/bdrs_pkg.sv
// Package for the block-decomposed range sum engine.
// Holds field widths, operation codes and the sequencer state type.
// No dependencies.
package bdrs_pkg;

  localparam int INDEX_W = 10;
  localparam int VALUE_W = 32;
  localparam int SUM_W   = 42;
  localparam int BSIZE_W = 11;
  localparam int DIFF_W  = VALUE_W + 1;
  localparam int POS_W   = INDEX_W + 1;

  localparam logic [BSIZE_W-1:0] BSIZE_RESET = 11'd32;

  localparam logic OP_ASSIGN = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  typedef enum logic [8:0] {
    ST_CLEAR  = 9'b000000001,
    ST_IDLE   = 9'b000000010,
    ST_DIVIDE = 9'b000000100,
    ST_READ   = 9'b000001000,
    ST_DIFF   = 9'b000010000,
    ST_WRITE  = 9'b000100000,
    ST_WALK   = 9'b001000000,
    ST_DRAIN  = 9'b010000000,
    ST_FINISH = 9'b100000000
  } state_t;

endpackage

// File: design/block_decomposed_range_sum.sv
// Block-decomposed range sum engine: entry store, block sum store and sequencer.
// Depends on bdrs_pkg.
//
// After reset the block sweeps both stores to zero, one address per cycle, and
// takes no transaction until the sweep is done. Every assign to an index in
// range and every query with a non-empty range first runs a shared restoring
// divider, one quotient bit per cycle, to find the block of the first index and
// the offset in it. An assign then reads, takes the difference and writes back.
// A query walks the range with one read per cycle from the single read port of
// either store: one read per entry in the ragged ends and one per whole block
// between them. The walk then sees the end of the range, a drain state takes
// the last read data and a finish state loads the result register. An empty
// range skips the walk and returns zero. The result register lets the next
// transaction start while a result still waits to be taken.
module block_decomposed_range_sum
  import bdrs_pkg::*;
#(
  parameter int MAX_ENTRIES = 1024
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      block_size_we,
  input  logic [BSIZE_W-1:0]        block_size_wdata,
  input  logic                      item_valid,
  output logic                      item_stall,
  input  logic                      operation,
  input  logic [INDEX_W-1:0]        first_index,
  input  logic [INDEX_W-1:0]        last_index,
  input  logic signed [VALUE_W-1:0] new_value,
  output logic                      result_valid,
  input  logic                      result_stall,
  output logic signed [SUM_W-1:0]   range_sum
);

  localparam int AW       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int LAST_INT = (MAX_ENTRIES > 2**INDEX_W) ? 2**INDEX_W - 1 : MAX_ENTRIES - 1;
  localparam logic [INDEX_W-1:0] LAST_MAX  = INDEX_W'(LAST_INT);
  localparam logic [AW-1:0]      CLEAR_END = AW'(MAX_ENTRIES - 1);
  localparam int CNT_W = $clog2(INDEX_W);
  localparam logic [CNT_W-1:0]   DIV_LAST  = CNT_W'(INDEX_W - 1);

  logic signed [VALUE_W-1:0] entry_mem [MAX_ENTRIES];
  logic signed [SUM_W-1:0]   bsum_mem  [MAX_ENTRIES];

  state_t                    state;
  logic [BSIZE_W-1:0]        block_size;
  logic [BSIZE_W-1:0]        bs_eff;
  logic [BSIZE_W-1:0]        bs_q;
  logic                      op_q;
  logic [POS_W-1:0]          pos;
  logic [INDEX_W-1:0]        hi;
  logic signed [VALUE_W-1:0] val_q;
  logic [CNT_W-1:0]          div_cnt;
  logic [INDEX_W-1:0]        quot;
  logic [BSIZE_W-1:0]        rem;
  logic signed [SUM_W-1:0]   acc;
  logic signed [DIFF_W-1:0]  diff_q;
  logic                      ent_pend;
  logic                      blk_pend;
  logic [AW-1:0]             clr_cnt;
  logic signed [VALUE_W-1:0] entry_q;
  logic signed [SUM_W-1:0]   bsum_q;

  logic                      accept;
  logic [INDEX_W-1:0]        last_sat;
  logic [BSIZE_W:0]          div_part;
  logic [BSIZE_W+1:0]        div_trial;
  logic                      div_ge;
  logic                      pos_end;
  logic [POS_W:0]            span_end;
  logic                      whole;
  logic [BSIZE_W-1:0]        rem_inc;
  logic                      ent_re;
  logic                      blk_re;
  logic                      ent_we;
  logic                      blk_we;
  logic [AW-1:0]             ent_waddr;
  logic [AW-1:0]             blk_waddr;
  logic signed [VALUE_W-1:0] ent_wdata;
  logic signed [SUM_W-1:0]   blk_wdata;
  logic                      result_free;

  assign item_stall  = (state != ST_IDLE);
  assign accept      = item_valid && !item_stall;
  assign bs_eff      = (block_size == '0) ? BSIZE_W'(1) : block_size;
  assign last_sat    = (last_index > LAST_MAX) ? LAST_MAX : last_index;
  assign result_free = !result_valid || !result_stall;

  assign div_part  = {rem, quot[INDEX_W-1]};
  assign div_trial = {1'b0, div_part} - {2'b00, bs_q};
  assign div_ge    = !div_trial[BSIZE_W+1];

  assign pos_end  = pos > {1'b0, hi};
  assign span_end = {1'b0, pos} + {1'b0, bs_q};
  assign whole    = (rem == '0) && (span_end <= ({2'b00, hi} + (POS_W+1)'(1)));
  assign rem_inc  = rem + BSIZE_W'(1);

  always_comb begin
    ent_re    = 1'b0;
    blk_re    = 1'b0;
    ent_we    = 1'b0;
    blk_we    = 1'b0;
    ent_waddr = AW'(pos);
    blk_waddr = AW'(quot);
    ent_wdata = val_q;
    blk_wdata = bsum_q + SUM_W'(diff_q);
    unique case (state)
      ST_CLEAR: begin
        ent_we    = 1'b1;
        blk_we    = 1'b1;
        ent_waddr = clr_cnt;
        blk_waddr = clr_cnt;
        ent_wdata = '0;
        blk_wdata = '0;
      end
      ST_READ: begin
        ent_re = 1'b1;
        blk_re = 1'b1;
      end
      ST_WRITE: begin
        ent_we = 1'b1;
        blk_we = 1'b1;
      end
      ST_WALK: begin
        ent_re = !pos_end && !whole;
        blk_re = !pos_end && whole;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ent_we) begin
      entry_mem[ent_waddr] <= ent_wdata;
    end
    if (ent_re) begin
      entry_q <= entry_mem[AW'(pos)];
    end
  end

  always_ff @(posedge clk) begin
    if (blk_we) begin
      bsum_mem[blk_waddr] <= blk_wdata;
    end
    if (blk_re) begin
      bsum_q <= bsum_mem[AW'(quot)];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      block_size <= BSIZE_RESET;
    end else if (block_size_we) begin
      block_size <= block_size_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_cnt  <= '0;
      ent_pend <= 1'b0;
      blk_pend <= 1'b0;
    end else begin
      ent_pend <= (state == ST_WALK) && ent_re;
      blk_pend <= (state == ST_WALK) && blk_re;
      if (ent_pend) begin
        acc <= acc + SUM_W'(entry_q);
      end else if (blk_pend) begin
        acc <= acc + bsum_q;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + AW'(1);
          if (clr_cnt == CLEAR_END) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            op_q    <= operation;
            pos     <= {1'b0, first_index};
            hi      <= last_sat;
            val_q   <= new_value;
            bs_q    <= bs_eff;
            quot    <= first_index;
            rem     <= '0;
            div_cnt <= '0;
            acc     <= '0;
            if (operation == OP_ASSIGN) begin
              if (first_index <= LAST_MAX) begin
                state <= ST_DIVIDE;
              end
            end else if (first_index > last_sat) begin
              state <= ST_FINISH;
            end else begin
              state <= ST_DIVIDE;
            end
          end
        end
        ST_DIVIDE: begin
          rem     <= div_ge ? div_trial[BSIZE_W-1:0] : div_part[BSIZE_W-1:0];
          quot    <= {quot[INDEX_W-2:0], div_ge};
          div_cnt <= div_cnt + CNT_W'(1);
          if (div_cnt == DIV_LAST) begin
            state <= (op_q == OP_QUERY) ? ST_WALK : ST_READ;
          end
        end
        ST_READ: begin
          state <= ST_DIFF;
        end
        ST_DIFF: begin
          diff_q <= DIFF_W'(val_q) - DIFF_W'(entry_q);
          state  <= ST_WRITE;
        end
        ST_WRITE: begin
          state <= ST_IDLE;
        end
        ST_WALK: begin
          if (pos_end) begin
            state <= ST_DRAIN;
          end else if (whole) begin
            pos  <= span_end[POS_W-1:0];
            quot <= quot + INDEX_W'(1);
          end else begin
            pos <= pos + POS_W'(1);
            if (rem_inc == bs_q) begin
              rem  <= '0;
              quot <= quot + INDEX_W'(1);
            end else begin
              rem <= rem_inc;
            end
          end
        end
        ST_DRAIN: begin
          state <= ST_FINISH;
        end
        ST_FINISH: begin
          if (result_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if ((state == ST_FINISH) && result_free) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_FINISH) && result_free) begin
      range_sum <= acc;
    end
  end

`ifndef NO_ASSERTIONS
  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state == ST_FINISH))
    else $error("result appeared without a finished query");

  a_clear_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> item_stall)
    else $error("transaction possible during clearing sweep");

  a_walk_offset: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK) |-> (rem < bs_q))
    else $error("block offset out of range during walk");

  a_idle_no_pending: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (!ent_pend && !blk_pend))
    else $error("read data still pending when idle");

  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK) |-> (span_end > {1'b0, pos}) && (pos <= ({1'b0, hi} + POS_W'(1))))
    else $error("walk position beyond range");
`endif

endmodule

// File: sim/range_sum_checker.sv
// Checker for the block-decomposed range sum engine: predicts every range sum
// from the accepted transactions and compares it with what the block returns.
// Depends on bdrs_pkg.
module range_sum_checker
  import bdrs_pkg::*;
#(
  parameter int MAX_ENTRIES = 1024
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      block_size_we,
  input  logic [BSIZE_W-1:0]        block_size_wdata,
  input  logic                      item_valid,
  input  logic                      item_stall,
  input  logic                      operation,
  input  logic [INDEX_W-1:0]        first_index,
  input  logic [INDEX_W-1:0]        last_index,
  input  logic signed [VALUE_W-1:0] new_value,
  input  logic                      result_valid,
  input  logic                      result_stall,
  input  logic signed [SUM_W-1:0]   range_sum,
  output int                        fail_count,
  output int                        pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  logic signed [VALUE_W-1:0] entry_values [MAX_ENTRIES];
  logic signed [SUM_W-1:0]   group_sums [MAX_ENTRIES];
  logic [BSIZE_W-1:0]        group_size;
  logic signed [SUM_W-1:0]   expected_sums [$];

  function automatic int unsigned grouping();
    return (group_size == 0) ? 1 : int'(group_size);
  endfunction

  function automatic void apply_assign(input int unsigned idx,
                                       input logic signed [VALUE_W-1:0] val);
    int unsigned slot;
    if (idx < MAX_ENTRIES) begin
      slot = (idx / grouping()) % MAX_ENTRIES;
      group_sums[slot] = SUM_W'(longint'(group_sums[slot]) + longint'(val)
                                - longint'(entry_values[idx]));
      entry_values[idx] = val;
    end
  endfunction

  function automatic logic signed [SUM_W-1:0] predict_range_sum(input int unsigned lo,
                                                               input int unsigned hi);
    int unsigned grp;
    int unsigned pos;
    longint acc;
    grp = grouping();
    acc = 0;
    if (hi > MAX_ENTRIES - 1) hi = MAX_ENTRIES - 1;
    pos = lo;
    while (pos <= hi) begin
      if ((pos % grp) == 0 && pos + grp - 1 <= hi) begin
        acc += longint'(group_sums[(pos / grp) % MAX_ENTRIES]);
        pos += grp;
      end else begin
        acc += longint'(entry_values[pos % MAX_ENTRIES]);
        pos += 1;
      end
    end
    return acc[SUM_W-1:0];
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        entry_values[i] = '0;
        group_sums[i] = '0;
      end
      group_size = BSIZE_RESET;
      expected_sums.delete();
    end else begin
      if (block_size_we) group_size = block_size_wdata;
      if (result_valid && !result_stall) begin
        if (expected_sums.size() == 0) begin
          $display("%0t: unexpected range_sum transaction, expected none, actual %0d",
                   $time, range_sum);
          fail_count++;
        end else begin
          if (range_sum !== expected_sums[0]) begin
            $display("%0t: range_sum mismatch, expected %0d, actual %0d",
                     $time, expected_sums[0], range_sum);
            fail_count++;
          end
          void'(expected_sums.pop_front());
        end
      end
      if (item_valid && !item_stall) begin
        if (operation == OP_ASSIGN) begin
          apply_assign(int'(first_index), new_value);
        end else begin
          expected_sums.push_back(predict_range_sum(int'(first_index), int'(last_index)));
        end
      end
    end
    pending_count = expected_sums.size();
  end

endmodule

// File: sim/block_decomposed_range_sum_tb.sv
// Top of the range sum testbench: clock, reset, block size settings, assign and
// query stimulus with idle and stall patterns, watchdog and verdict.
// Depends on bdrs_pkg, block_decomposed_range_sum and range_sum_checker.
module block_decomposed_range_sum_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bdrs_pkg::*;

  localparam int ENTRY_COUNT    = 1024;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_CYCLES    = 1500;
  localparam int SETTLE_CYCLES  = 40;

  logic                      clk;
  logic                      rst;
  logic                      block_size_we;
  logic [BSIZE_W-1:0]        block_size_wdata;
  logic                      item_valid;
  logic                      item_stall;
  logic                      operation;
  logic [INDEX_W-1:0]        first_index;
  logic [INDEX_W-1:0]        last_index;
  logic signed [VALUE_W-1:0] new_value;
  logic                      result_valid;
  logic                      result_stall;
  logic signed [SUM_W-1:0]   range_sum;

  int idle_pct;
  int stall_pct;
  int hold_left;
  int idle_cycles;
  bit hold_go;
  bit hold_seen;
  int fail_count;
  int pending_count;

  block_decomposed_range_sum #(.MAX_ENTRIES(ENTRY_COUNT)) dut (
    .clk(clk),
    .rst(rst),
    .block_size_we(block_size_we),
    .block_size_wdata(block_size_wdata),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .operation(operation),
    .first_index(first_index),
    .last_index(last_index),
    .new_value(new_value),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .range_sum(range_sum)
  );

  range_sum_checker #(.MAX_ENTRIES(ENTRY_COUNT)) scoreboard (
    .clk(clk),
    .rst(rst),
    .block_size_we(block_size_we),
    .block_size_wdata(block_size_wdata),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .operation(operation),
    .first_index(first_index),
    .last_index(last_index),
    .new_value(new_value),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .range_sum(range_sum),
    .fail_count(fail_count),
    .pending_count(pending_count)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(negedge clk) begin
    if (hold_go && !hold_seen) begin
      hold_seen = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      result_stall <= 1'b1;
    end else begin
      result_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles = 0;
    end else if ((item_valid && !item_stall) || (result_valid && !result_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("block_decomposed_range_sum_tb failed");
        $finish;
      end
    end
  end

  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_item(input logic op, input int unsigned first, input int unsigned last,
                           input logic [VALUE_W-1:0] value);
    while ($urandom_range(0, 99) < idle_pct) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid <= 1'b1;
    operation <= op;
    first_index <= first[INDEX_W-1:0];
    last_index <= last[INDEX_W-1:0];
    new_value <= value;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_random(input int unsigned span);
    int unsigned a;
    int unsigned b;
    int unsigned pick;
    a = $urandom_range(0, ENTRY_COUNT - 1);
    if ($urandom_range(0, 1) == 0) begin
      send_item(OP_ASSIGN, a, $urandom_range(0, ENTRY_COUNT - 1), pick_value());
    end else begin
      pick = $urandom_range(0, 9);
      if (pick < 8) begin
        b = a + $urandom_range(0, span);
        if (b > ENTRY_COUNT - 1) b = ENTRY_COUNT - 1;
      end else if (pick == 8 && a > 0) begin
        b = $urandom_range(0, a - 1);
      end else begin
        a = a & ~32'd31;
        b = a | 32'd31;
      end
      send_item(OP_QUERY, a, b, $urandom);
    end
  endtask

  task automatic run_random(input int count, input int unsigned span);
    for (int k = 0; k < count; k++) begin
      case ((k * 4) / count)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 51; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 51; end
        default: begin idle_pct = 13; stall_pct = 13; end
      endcase
      send_random(span);
    end
  endtask

  task automatic settle();
    item_valid <= 1'b0;
    @(negedge clk);
    while (pending_count != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_block_size(input int unsigned value);
    block_size_we <= 1'b1;
    block_size_wdata <= value[BSIZE_W-1:0];
    @(negedge clk);
    block_size_we <= 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    block_size_we = 1'b0;
    block_size_wdata = '0;
    item_valid = 1'b0;
    operation = OP_ASSIGN;
    first_index = '0;
    last_index = '0;
    new_value = '0;
    idle_pct = 0;
    stall_pct = 0;
    hold_go = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_item(OP_QUERY, 0, 1023, 0);
    send_item(OP_ASSIGN, 0, 0, 32'h7fff_ffff);
    send_item(OP_ASSIGN, 1023, 0, 32'h8000_0000);
    send_item(OP_ASSIGN, 31, 0, 32'hffff_ffff);
    send_item(OP_ASSIGN, 32, 0, 32'd12345);
    send_item(OP_ASSIGN, 0, 0, 32'h7fff_ffff);
    send_item(OP_ASSIGN, 500, 1023, 32'h5a5a_5a5a);
    send_item(OP_QUERY, 0, 1023, 0);
    send_item(OP_QUERY, 0, 0, 0);
    send_item(OP_QUERY, 1023, 1023, 0);
    send_item(OP_QUERY, 5, 3, 0);
    send_item(OP_QUERY, 1023, 0, 0);
    send_item(OP_QUERY, 31, 32, 0);
    send_item(OP_QUERY, 0, 31, 0);
    send_item(OP_QUERY, 32, 63, 0);
    send_item(OP_QUERY, 1, 1022, 0);
    send_item(OP_QUERY, 32, 1023, 0);
    send_item(OP_ASSIGN, 32, 0, 32'd0);
    send_item(OP_QUERY, 0, 63, 0);
    run_random(300, 1023);

    settle();
    write_block_size(1);
    run_random(60, 48);

    settle();
    write_block_size(1024);
    run_random(60, 200);

    settle();
    write_block_size(0);
    run_random(40, 48);

    settle();
    write_block_size(2047);
    run_random(40, 100);

    settle();
    write_block_size($urandom_range(2, 40));
    run_random(200, 1023);

    settle();
    write_block_size(BSIZE_RESET);
    idle_pct = 0;
    stall_pct = 0;
    hold_go = 1'b1;
    repeat (20) send_item(OP_QUERY, $urandom_range(0, 100), $urandom_range(900, 1023), 0);
    run_random(110, 1023);

    item_valid <= 1'b0;
    @(negedge clk);
    while (pending_count != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("block_decomposed_range_sum_tb passed");
    end else begin
      $display("block_decomposed_range_sum_tb failed");
    end
    $finish;
  end

endmodule
